// File: rtl/nst_pkg.sv
// Shared types, constants and the sine table for the noisy sine test tone.
`default_nettype none
package nst_pkg;

   // beat field widths
   localparam int PHASE_W     = 4;
   localparam int COUNT_W     = 7;
   localparam int SAMPLE_W    = 15;
   localparam int SEED_W      = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 16;

   localparam int MAX_BURST_DEFAULT = 64;
   localparam int QUEUE_DEPTH       = 2;

   // register index decode (paddr[2] selects the word)
   localparam logic IDX_SEED = 1'b0;
   localparam logic [SEED_W-1:0] SEED_RESET = 32'd1;

   // mod 2001 by reciprocal: q = (x * NOISE_RECIP) >> NOISE_SHIFT, low by at most 1
   localparam int                NOISE_SHIFT  = 42;
   localparam logic [31:0]       NOISE_RECIP  = 32'd2197924293;
   localparam int                QUOT_W       = 64 - NOISE_SHIFT;
   localparam int                REM_W        = 12;
   localparam logic [10:0]       NOISE_SPAN   = 11'd2001;
   localparam logic signed [SAMPLE_W-1:0] NOISE_OFFSET = 15'sd1000;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [PHASE_W-1:0] start;
   } nst_entry_type;

   typedef struct packed {
      logic          valid;
      nst_entry_type entry;
   } nst_push_type;

   typedef struct packed {
      logic              load;
      logic [SEED_W-1:0] value;
   } nst_seed_load_type;

   // 8000 * sin(2*pi*k/16), rounded
   function automatic logic signed [SAMPLE_W-1:0] tone_value(input logic [PHASE_W-1:0] k);
      logic signed [SAMPLE_W-1:0] v;
      case (k)
         4'd0:    v = 15'sd0;
         4'd1:    v = 15'sd3061;
         4'd2:    v = 15'sd5657;
         4'd3:    v = 15'sd7391;
         4'd4:    v = 15'sd8000;
         4'd5:    v = 15'sd7391;
         4'd6:    v = 15'sd5657;
         4'd7:    v = 15'sd3061;
         4'd8:    v = 15'sd0;
         4'd9:    v = -15'sd3061;
         4'd10:   v = -15'sd5657;
         4'd11:   v = -15'sd7391;
         4'd12:   v = -15'sd8000;
         4'd13:   v = -15'sd7391;
         4'd14:   v = -15'sd5657;
         default: v = -15'sd3061;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// File: rtl/nst_front.sv
// Request front end: drops empty bursts, clamps the length, feeds the queue.
`default_nettype none
module nst_front
   import nst_pkg::*;
#(
   parameter int MAX_BURST = MAX_BURST_DEFAULT
) (
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output      logic               req_tready,
   input  wire logic [PHASE_W-1:0] req_start,
   input  wire logic [COUNT_W-1:0] req_count,
   input  wire logic               queue_full,
   output      nst_push_type       push
);

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_BURST);

   logic accept;

   // no beat is taken while reset is high
   assign req_tready = ~queue_full & ~reset;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      push.valid       = accept && (req_count != '0);
      push.entry.start = req_start;
      push.entry.count = (req_count > MAX_COUNT) ? MAX_COUNT : req_count;
   end

endmodule
`default_nettype wire

// File: rtl/nst_queue.sv
// Small flop FIFO of pending bursts between front end and sample engine.
`default_nettype none
module nst_queue
   import nst_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire nst_push_type push,
   input  wire logic   pop,
   output      logic   full,
   output      logic   empty,
   output nst_entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   nst_entry_type    store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full    = (fill_ff == FULL_CNT);
   assign empty   = (fill_ff == '0);
   assign do_push = push.valid & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push.entry;
      end
   end

endmodule
`default_nettype wire

// File: rtl/nst_back.sv
// Sample engine: burst sequencer, xorshift, mod-2001 pipeline, output register.
`default_nettype none
module nst_back
   import nst_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire nst_seed_load_type   seed_load,
   input  wire logic                queue_empty,
   input  wire nst_entry_type       queue_head,
   output      logic                queue_pop,
   output      logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   output      logic [SAMPLE_W-1:0] rsp_sample,
   output      logic                rsp_last
);

   // whole pipe moves together; stalls only when the output beat is held
   logic en, issue;

   logic               active_ff, active_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [COUNT_W-1:0] left_ff, left_in;
   logic [SEED_W-1:0]  rng_ff, rng_in, rng_next;

   // stage 1: fresh generator value
   logic               s1_valid_ff;
   logic [31:0]        s1_x_ff;
   logic [PHASE_W-1:0] s1_phase_ff;
   logic               s1_last_ff;
   // stage 2: quotient estimate
   logic               s2_valid_ff;
   logic [QUOT_W-1:0]  s2_q_ff, s2_q_in;
   logic [REM_W-1:0]   s2_xlo_ff;
   logic [PHASE_W-1:0] s2_phase_ff;
   logic               s2_last_ff;
   // stage 3: remainder in 0..4001
   logic               s3_valid_ff;
   logic [REM_W-1:0]   s3_rem_ff, s3_rem_in;
   logic [PHASE_W-1:0] s3_phase_ff;
   logic               s3_last_ff;
   // output beat
   logic                       out_valid_ff;
   logic signed [SAMPLE_W-1:0] out_sample_ff, out_sample_in;
   logic                       out_last_ff;

   logic [63:0]        prod1;
   logic [QUOT_W+10:0] prod2;
   logic [REM_W-1:0]   rem_fix;
   logic signed [SAMPLE_W-1:0] noise;

   assign en        = ~out_valid_ff | rsp_tready;
   assign issue     = en & active_ff;
   assign queue_pop = en & ~active_ff & ~queue_empty;

   always_comb begin
      logic [31:0] x;
      x        = rng_ff;
      x        = x ^ (x << 13);
      x        = x ^ (x >> 17);
      x        = x ^ (x << 5);
      rng_next = x;
   end

   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      left_in   = left_ff;
      rng_in    = rng_ff;
      if (seed_load.load) begin
         rng_in = (seed_load.value == '0) ? SEED_RESET : seed_load.value;
      end else if (issue) begin
         rng_in = rng_next;
      end
      if (issue) begin
         phase_in = phase_ff + 1'b1;
         left_in  = left_ff - 1'b1;
         if (left_ff == COUNT_W'(1)) begin
            active_in = 1'b0;
         end
      end else if (queue_pop) begin
         active_in = 1'b1;
         phase_in  = queue_head.start;
         left_in   = queue_head.count;
      end
   end

   assign prod1   = 64'(s1_x_ff) * 64'(NOISE_RECIP);
   assign s2_q_in = prod1[63:NOISE_SHIFT];

   assign prod2     = s2_q_ff * NOISE_SPAN;
   assign s3_rem_in = s2_xlo_ff - prod2[REM_W-1:0];

   assign rem_fix = (s3_rem_ff >= REM_W'(NOISE_SPAN)) ? s3_rem_ff - REM_W'(NOISE_SPAN)
                                                      : s3_rem_ff;
   assign noise         = $signed(SAMPLE_W'(rem_fix)) - NOISE_OFFSET;
   assign out_sample_in = tone_value(s3_phase_ff) + noise;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         phase_ff     <= '0;
         left_ff      <= '0;
         rng_ff       <= SEED_RESET;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         rng_ff    <= rng_in;
         if (en) begin
            s1_valid_ff  <= issue;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff;
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_x_ff       <= rng_next;
         s1_phase_ff   <= phase_ff;
         s1_last_ff    <= (left_ff == COUNT_W'(1));
         s2_q_ff       <= s2_q_in;
         s2_xlo_ff     <= s1_x_ff[REM_W-1:0];
         s2_phase_ff   <= s1_phase_ff;
         s2_last_ff    <= s1_last_ff;
         s3_rem_ff     <= s3_rem_in;
         s3_phase_ff   <= s2_phase_ff;
         s3_last_ff    <= s2_last_ff;
         out_sample_ff <= out_sample_in;
         out_last_ff   <= s3_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_sample = out_sample_ff;
   assign rsp_last   = out_last_ff;

endmodule
`default_nettype wire

// File: rtl/noisy_sine_test_tone.sv
// Top level of the noisy sine test tone generator.
// Each request beat carries a start phase and a burst length; the block answers
// with that many sample beats, the last one flagged on rsp_tlast. Each sample is
// a 16-entry sine table value (amplitude 8000) plus xorshift32 noise in
// -1000..1000. A burst streams at one beat per cycle once started, unless the
// output is held. Each burst is picked off the two-entry request queue, and each
// sample then passes the noise pipe registers (generator, reciprocal multiply,
// remainder, table add). Output back-pressure stalls the whole sample pipe; up
// to two further requests are queued while a burst runs. Empty bursts are
// dropped, lengths above MAX_BURST are clamped. Writing the seed register (byte
// address 0) reloads the generator, a zero seed loading 1; write it only while
// the block is idle. There is no clearing pass after reset.
`default_nettype none
module noisy_sine_test_tone
   import nst_pkg::*;
#(
   parameter int MAX_BURST = MAX_BURST_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [3:0] start_phase, [10:4] count, rest zero
   // sample channel
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,   // [14:0] sample (signed), [15] zero
   output      logic                  rsp_tlast,
   // register port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);

   logic [SEED_W-1:0] seed_ff, seed_in;
   logic              csr_wr, idx_hit;
   nst_seed_load_type seed_load;
   nst_push_type      push;
   nst_entry_type     head;
   logic              queue_full, queue_empty, queue_pop;
   logic [SAMPLE_W-1:0] sample;

   // register file: one word, seed
   assign csr_pready = 1'b1;
   assign idx_hit    = (csr_paddr[2] == IDX_SEED);
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign seed_in    = (csr_wr && idx_hit) ? csr_pwdata : seed_ff;
   assign csr_prdata = idx_hit ? seed_ff : '0;

   always_comb begin
      seed_load.load  = csr_wr & idx_hit;
      seed_load.value = csr_pwdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   nst_front #(
      .MAX_BURST (MAX_BURST)
   ) u_front (
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_start  (req_tdata[PHASE_W-1:0]),
      .req_count  (req_tdata[PHASE_W+COUNT_W-1:PHASE_W]),
      .queue_full (queue_full),
      .push       (push)
   );

   nst_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (queue_pop),
      .full  (queue_full),
      .empty (queue_empty),
      .head  (head)
   );

   nst_back u_back (
      .clock       (clock),
      .reset       (reset),
      .seed_load   (seed_load),
      .queue_empty (queue_empty),
      .queue_head  (head),
      .queue_pop   (queue_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_sample  (sample),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {{(RSP_DATA_W-SAMPLE_W){1'b0}}, sample};

endmodule
`default_nettype wire

// File: rtl/nst_checker.sv
// Port-level checks for the noisy sine test tone, bound to the top level.
`default_nettype none
module nst_checker
   import nst_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                  rsp_tlast
);

   // held sample beat keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("sample beat changed while stalled");

   // nothing left in flight after a reset cycle
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("sample beat right after reset");

   // tone plus noise stays within the amplitude budget, pad bit clear
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[SAMPLE_W-1:0]) >= -15'sd9000)
                  && ($signed(rsp_tdata[SAMPLE_W-1:0]) <= 15'sd9000)
                  && (rsp_tdata[RSP_DATA_W-1] == 1'b0))
      else $error("sample out of range");

endmodule

bind noisy_sine_test_tone nst_checker u_nst_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
